### sv/cif_pkg.sv
package cif_pkg;

    localparam int ID_W          = 29;
    localparam int LEN_W         = 7;
    localparam int DATA_W        = 64;
    localparam int PAYLOAD_BYTES = 8;

    // item opcodes
    localparam logic [1:0] OP_FRAME  = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // result status codes
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [ID_W-1:0]   can_id;
        logic [LEN_W-1:0]  frame_len;
        logic [DATA_W-1:0] frame_data;
        logic              rule_active;
        logic              rule_block;
        logic              rule_modify;
        logic [DATA_W-1:0] rule_mask;
        logic [DATA_W-1:0] rule_payload;
    } in_word_t;

    typedef struct packed {
        logic              blocked;
        logic              modified;
        logic [DATA_W-1:0] data_out;
        logic              status;
    } out_word_t;

    // rule body kept in the slot memory
    typedef struct packed {
        logic              active;
        logic              block;
        logic              modify;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] payload;
    } rule_entry_t;

    // identifier table update command
    typedef struct packed {
        logic set;
        logic clear;
    } cam_cmd_t;

endpackage

### sv/cif_id_cam.sv
module cif_id_cam #(
    parameter int RULE_SLOTS = 16,
    parameter int SLOT_W     = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [cif_pkg::ID_W-1:0]  lookup_id,
    output logic                      hit,
    output logic [SLOT_W-1:0]         hit_idx,
    output logic                      free_found,
    output logic [SLOT_W-1:0]         free_idx,
    input  cif_pkg::cam_cmd_t         cmd,
    input  logic [SLOT_W-1:0]         cmd_idx,
    input  logic [cif_pkg::ID_W-1:0]  cmd_id
);

    logic [RULE_SLOTS-1:0]    valid_reg;
    logic [cif_pkg::ID_W-1:0] id_reg [RULE_SLOTS];
    logic [RULE_SLOTS-1:0]    hit_vec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.set)
        begin
            valid_reg[cmd_idx] <= 1'b1;
        end
        else if (cmd.clear)
        begin
            valid_reg[cmd_idx] <= 1'b0;
        end
    end

    // identifiers are only compared while their slot is valid
    always_ff @(posedge clk)
    begin
        if (cmd.set)
        begin
            id_reg[cmd_idx] <= cmd_id;
        end
    end

    // parallel compare, at most one slot can match
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < RULE_SLOTS; i++)
        begin
            hit_vec[i] = valid_reg[i] && (id_reg[i] == lookup_id);
            if (hit_vec[i])
            begin
                hit_idx = hit_idx | SLOT_W'(i);
            end
        end
        hit = |hit_vec;
    end

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = RULE_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("identifier held by more than one slot");

    a_set_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set |=> valid_reg[$past(cmd_idx)])
        else $error("slot not valid after rule write");

endmodule

### sv/can_id_filter_payload_rewriter_unit.sv
// can identifier filter with masked payload rewrite
//
// item channel (item_valid / item_stall / item) carries one word per item:
// a frame to look up, a rule to add or replace, or a rule to remove.
// result channel (result_valid / result_stall / result) returns exactly one
// word per item, in order.
// rule identifiers sit in a flop table compared in parallel; the rule body
// (flags, mask, payload) lives in a single-port-style slot memory with a
// registered read.
// add, remove and unused opcodes: the table is updated at the accept edge and
// the result word is loaded the same edge, so these run one item per cycle
// while the result channel does not stall. frames: the slot memory read is
// registered and the merged word is loaded into the result register in the
// read state; the next item is taken once the frame has left that state.
// a full table rejects an add with status full and leaves the table as is.
// reset clears the slot valid bits, the state machine and the result valid
// flag; no clearing pass is needed.
// while result_stall holds a valid word, that word stays put and item_stall
// is high, so no further item is taken; a frame in its read cycle always
// finds the result register empty and never waits.
module can_id_filter_payload_rewriter_unit #(
    parameter int RULE_SLOTS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  cif_pkg::in_word_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output cif_pkg::out_word_t result
);

    localparam int SLOT_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;

    // fsm and result register
    cif_pkg::state_t    state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    cif_pkg::out_word_t out_word_reg, out_word_next;

    // frame held while the slot memory is read
    logic                          hit_reg, hit_next;
    logic [cif_pkg::LEN_W-1:0]     len_reg, len_next;
    logic [cif_pkg::DATA_W-1:0]    data_reg, data_next;

    // slot memory
    cif_pkg::rule_entry_t rule_mem [RULE_SLOTS];
    cif_pkg::rule_entry_t rd_data_reg;
    cif_pkg::rule_entry_t wr_entry;
    logic                 mem_we;
    logic                 mem_re;
    logic [SLOT_W-1:0]    mem_widx;

    // identifier table
    logic                 hit;
    logic [SLOT_W-1:0]    hit_idx;
    logic                 free_found;
    logic [SLOT_W-1:0]    free_idx;
    cif_pkg::cam_cmd_t    cam_cmd;

    logic                 out_free;
    logic                 accept;
    logic [cif_pkg::DATA_W-1:0] span;
    logic [cif_pkg::DATA_W-1:0] merge_mask;

    cif_id_cam #(
        .RULE_SLOTS (RULE_SLOTS),
        .SLOT_W     (SLOT_W)
    ) u_id_cam (
        .clk        (clk),
        .rst_n      (rst_n),
        .lookup_id  (item.can_id),
        .hit        (hit),
        .hit_idx    (hit_idx),
        .free_found (free_found),
        .free_idx   (free_idx),
        .cmd        (cam_cmd),
        .cmd_idx    (mem_widx),
        .cmd_id     (item.can_id)
    );

    // result slot is free if empty or being drained this edge
    assign out_free     = !out_valid_reg || !result_stall;
    assign item_stall   = !((state_reg == cif_pkg::ST_IDLE) && out_free);
    assign accept       = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

    // bytes below frame_len take part in the rewrite
    always_comb
    begin
        for (int b = 0; b < cif_pkg::PAYLOAD_BYTES; b++)
        begin
            span[8*b +: 8] = {8{(len_reg > cif_pkg::LEN_W'(b))}};
        end
        merge_mask = rd_data_reg.mask & span;
    end

    assign wr_entry = '{active:  item.rule_active,
                        block:   item.rule_block,
                        modify:  item.rule_modify,
                        mask:    item.rule_mask,
                        payload: item.rule_payload};

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_word_next  = out_word_reg;
        hit_next       = hit_reg;
        len_next       = len_reg;
        data_next      = data_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_widx       = hit ? hit_idx : free_idx;
        cam_cmd        = '{set: 1'b0, clear: 1'b0};

        case (state_reg)
            cif_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    out_word_next = '{blocked:  1'b0,
                                      modified: 1'b0,
                                      data_out: '0,
                                      status:   cif_pkg::STATUS_DONE};
                    case (item.op)
                        cif_pkg::OP_FRAME:
                        begin
                            mem_re     = 1'b1;
                            hit_next   = hit;
                            len_next   = item.frame_len;
                            data_next  = item.frame_data;
                            state_next = cif_pkg::ST_READ;
                        end
                        cif_pkg::OP_ADD:
                        begin
                            out_valid_next = 1'b1;
                            if (hit || free_found)
                            begin
                                mem_we      = 1'b1;
                                cam_cmd.set = 1'b1;
                            end
                            else
                            begin
                                out_word_next.status = cif_pkg::STATUS_FULL;
                            end
                        end
                        cif_pkg::OP_REMOVE:
                        begin
                            out_valid_next = 1'b1;
                            cam_cmd.clear  = hit;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            cif_pkg::ST_READ:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_word_next.status        = cif_pkg::STATUS_DONE;
                    out_word_next.blocked       = hit_reg && rd_data_reg.active &&
                                                  rd_data_reg.block;
                    out_word_next.modified      = hit_reg && rd_data_reg.active &&
                                                  rd_data_reg.modify;
                    out_word_next.data_out      = data_reg;
                    if (hit_reg && rd_data_reg.active && rd_data_reg.modify)
                    begin
                        out_word_next.data_out = (data_reg & ~merge_mask) |
                                                 (rd_data_reg.payload & merge_mask);
                    end
                    state_next = cif_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cif_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cif_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
        hit_reg      <= hit_next;
        len_reg      <= len_next;
        data_reg     <= data_next;
    end

    // slot memory: write on add, registered read on frame lookup; one item
    // at a time, so a read never overlaps a write to the same slot
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rule_mem[mem_widx] <= wr_entry;
        end
        if (mem_re)
        begin
            rd_data_reg <= rule_mem[hit_idx];
        end
    end

    a_read_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cif_pkg::ST_READ) |->
            ($past(accept && (item.op == cif_pkg::OP_FRAME)) ||
             $past(state_reg == cif_pkg::ST_READ)))
        else $error("read state entered without a frame");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |->
            ($past(accept) || $past(state_reg == cif_pkg::ST_READ)))
        else $error("result word appeared without an item");

    a_full_only_on_add: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.op == cif_pkg::OP_FRAME)) |=>
            (!out_valid_reg || !$past(result_stall) ||
             (out_word_reg.status == cif_pkg::STATUS_DONE) ||
             $stable(out_word_reg)))
        else $error("frame reported a table-full status");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int RULE_SLOTS       = 16;
    localparam int CLK_HALF         = 10;
    localparam int RESET_CYCLES     = 10;
    // slowest run: ~630 words, long gaps and stalls
    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_PER_PHASE = 200;
    localparam int DRAIN_CYCLES     = 10;
    localparam int ID_POOL_SIZE     = 24;

    localparam int ID_W   = cif_pkg::ID_W;
    localparam int LEN_W  = cif_pkg::LEN_W;
    localparam int DATA_W = cif_pkg::DATA_W;

    localparam logic [ID_W-1:0] ID_MAX    = '1;
    // opcode the block leaves unused
    localparam logic [1:0]      OP_UNUSED = 2'd3;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    logic               item_stall;
    cif_pkg::in_word_t  item         = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    cif_pkg::out_word_t result;

    can_id_filter_payload_rewriter_unit #(
        .RULE_SLOTS(RULE_SLOTS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // words waiting to be sent, and results owed by the block, oldest first
    cif_pkg::in_word_t  pending_items[$];
    cif_pkg::out_word_t expected_results[$];

    // idle rates in percent, changed between phases
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors         = 0;
    int cycle_count    = 0;

    // identifiers drawn from a small pool so rules get hit, replaced and
    // the table runs full
    logic [ID_W-1:0] id_pool [ID_POOL_SIZE];

    // shadow rule table
    logic                 rule_live  [RULE_SLOTS];
    logic [ID_W-1:0]      rule_ident [RULE_SLOTS];
    cif_pkg::rule_entry_t rule_body  [RULE_SLOTS];

    task automatic enqueue_pending(input cif_pkg::in_word_t w);
        pending_items = {pending_items, w};
    endtask

    task automatic enqueue_expected(input cif_pkg::out_word_t r);
        expected_results = {expected_results, r};
    endtask

    // apply one accepted word to the shadow table and return its result word
    function automatic cif_pkg::out_word_t apply_to_rule_table(input cif_pkg::in_word_t w);
        cif_pkg::out_word_t r;
        int                 hit;
        int                 free_slot;
        int                 i;
        logic [DATA_W-1:0]  span;
        logic [DATA_W-1:0]  sel;
        r         = '0;
        hit       = -1;
        free_slot = -1;
        for (i = 0; i < RULE_SLOTS; i++)
        begin
            if (rule_live[i] && rule_ident[i] == w.can_id && hit < 0)
                hit = i;
            if (!rule_live[i] && free_slot < 0)
                free_slot = i;
        end
        case (w.op)
            cif_pkg::OP_FRAME:
            begin
                r.data_out = w.frame_data;
                if (hit >= 0 && rule_body[hit].active)
                begin
                    r.blocked = rule_body[hit].block;
                    if (rule_body[hit].modify)
                    begin
                        // only the bytes actually in the frame, at most eight
                        if (w.frame_len >= LEN_W'(cif_pkg::PAYLOAD_BYTES))
                            span = '1;
                        else
                            span = (64'd1 << (8 * w.frame_len)) - 64'd1;
                        sel        = rule_body[hit].mask & span;
                        r.data_out = (w.frame_data & ~sel) | (rule_body[hit].payload & sel);
                        r.modified = 1'b1;
                    end
                end
            end
            cif_pkg::OP_ADD:
            begin
                // replace in place, else lowest free slot, else reject
                if (hit < 0)
                    hit = free_slot;
                if (hit < 0)
                    r.status = cif_pkg::STATUS_FULL;
                else
                begin
                    rule_live[hit]  = 1'b1;
                    rule_ident[hit] = w.can_id;
                    rule_body[hit]  = '{active: w.rule_active, block: w.rule_block,
                                        modify: w.rule_modify, mask: w.rule_mask,
                                        payload: w.rule_payload};
                end
            end
            cif_pkg::OP_REMOVE:
            begin
                // silent when nothing matches
                if (hit >= 0)
                    rule_live[hit] = 1'b0;
            end
            default:
            begin
                // unused opcode touches nothing
            end
        endcase
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // every field random, so fields an opcode ignores get exercised too
    function automatic cif_pkg::in_word_t random_word();
        cif_pkg::in_word_t w;
        w.op           = 2'($urandom_range(0, 3));
        w.can_id       = ID_W'($urandom);
        w.frame_len    = LEN_W'($urandom_range(0, 64));
        w.frame_data   = rand64();
        w.rule_active  = 1'($urandom_range(0, 1));
        w.rule_block   = 1'($urandom_range(0, 1));
        w.rule_modify  = 1'($urandom_range(0, 1));
        w.rule_mask    = rand64();
        w.rule_payload = rand64();
        return w;
    endfunction

    task automatic queue_word(input logic [1:0] op, input logic [ID_W-1:0] id,
                              input int len, input logic [DATA_W-1:0] data);
        cif_pkg::in_word_t w;
        w            = random_word();
        w.op         = op;
        w.can_id     = id;
        w.frame_len  = LEN_W'(len);
        w.frame_data = data;
        enqueue_pending(w);
    endtask

    task automatic queue_rule(input logic [ID_W-1:0] id, input logic active,
                              input logic block, input logic modify,
                              input logic [DATA_W-1:0] mask,
                              input logic [DATA_W-1:0] payload);
        cif_pkg::in_word_t w;
        w              = random_word();
        w.op           = cif_pkg::OP_ADD;
        w.can_id       = id;
        w.rule_active  = active;
        w.rule_block   = block;
        w.rule_modify  = modify;
        w.rule_mask    = mask;
        w.rule_payload = payload;
        enqueue_pending(w);
    endtask

    // mostly frames and rule traffic on pooled ids, a few stray ids and
    // unused opcodes
    task automatic queue_random_words(input int count);
        cif_pkg::in_word_t w;
        int                pick;
        int                n;
        for (n = 0; n < count; n++)
        begin
            w    = random_word();
            pick = $urandom_range(0, 99);
            if (pick < 45)
                w.op = cif_pkg::OP_FRAME;
            else if (pick < 75)
                w.op = cif_pkg::OP_ADD;
            else if (pick < 93)
                w.op = cif_pkg::OP_REMOVE;
            else
                w.op = OP_UNUSED;
            if ($urandom_range(0, 99) < 85)
                w.can_id = id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
            // short frames dominate so partial rewrites show up often
            pick = $urandom_range(0, 9);
            if (pick < 6)
                w.frame_len = LEN_W'($urandom_range(0, cif_pkg::PAYLOAD_BYTES));
            else if (pick < 9)
                w.frame_len = LEN_W'($urandom_range(cif_pkg::PAYLOAD_BYTES + 1, 64));
            else
                w.frame_len = LEN_W'(64);
            case ($urandom_range(0, 3))
                0: w.rule_mask = '1;
                1: w.rule_mask = '0;
                default: w.rule_mask = rand64();
            endcase
            w.rule_active = ($urandom_range(0, 3) != 0);
            enqueue_pending(w);
        end
    endtask

    // sender holds off until the block owes nothing
    task automatic wait_until_drained();
        while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        errors++;
    endtask

    task automatic check_result(input cif_pkg::out_word_t got);
        cif_pkg::out_word_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("result word with nothing owed", got.data_out, '0);
            return;
        end
        want = expected_results.pop_front();
        if (got.blocked !== want.blocked)
            report_mismatch("blocked", 64'(got.blocked), 64'(want.blocked));
        if (got.modified !== want.modified)
            report_mismatch("modified", 64'(got.modified), 64'(want.modified));
        if (got.data_out !== want.data_out)
            report_mismatch("data_out", got.data_out, want.data_out);
        if (got.status !== want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
    endtask

    // driver: predict on accept, hold the word while stalled, else maybe idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
                enqueue_expected(apply_to_rule_table(item));
            if (!item_valid || !item_stall)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    item_valid <= 1'b1;
                    item       <= pending_items.pop_front();
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // monitor: check accepted result words, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
                check_result(result);
            result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int i;
        for (i = 0; i < RULE_SLOTS; i++)
            rule_live[i] = 1'b0;
        id_pool[0] = '0;
        id_pool[1] = ID_MAX;
        for (i = 2; i < ID_POOL_SIZE; i++)
            id_pool[i] = ID_W'($urandom);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // phase one: sender idles a little, receiver stalls a lot
        send_idle_pct  = 30;
        recv_stall_pct = 78;

        // full-mask modify rule on the lowest id: long, short and empty frames
        queue_rule('0, 1'b1, 1'b0, 1'b1, '1, rand64());
        queue_word(cif_pkg::OP_FRAME, '0, 64, rand64());
        queue_word(cif_pkg::OP_FRAME, '0, 3, rand64());
        queue_word(cif_pkg::OP_FRAME, '0, 0, rand64());
        // block-only rule on the highest id
        queue_rule(ID_MAX, 1'b1, 1'b1, 1'b0, rand64(), rand64());
        queue_word(cif_pkg::OP_FRAME, ID_MAX, 8, '1);
        // replace in place with block and modify, random mask
        queue_rule('0, 1'b1, 1'b1, 1'b1, rand64(), rand64());
        queue_word(cif_pkg::OP_FRAME, '0, 8, '0);
        // inactive rule and a frame with no rule at all
        queue_rule(29'd5, 1'b0, 1'b1, 1'b1, '1, rand64());
        queue_word(cif_pkg::OP_FRAME, 29'd5, 8, rand64());
        queue_word(cif_pkg::OP_FRAME, 29'd12345, 8, rand64());
        // remove of an unknown id, then a real one
        queue_word(cif_pkg::OP_REMOVE, 29'd777, 0, '0);
        queue_word(cif_pkg::OP_REMOVE, ID_MAX, 0, '0);
        queue_word(cif_pkg::OP_FRAME, ID_MAX, 8, rand64());
        queue_word(OP_UNUSED, ID_W'($urandom), $urandom_range(0, 64), rand64());
        // fill the table, overflow it, replace while full, free a slot
        for (i = 2; i < RULE_SLOTS; i++)
            queue_rule(id_pool[i], 1'b1, 1'($urandom_range(0, 1)), 1'b1,
                       rand64(), rand64());
        queue_rule(id_pool[RULE_SLOTS], 1'b1, 1'b1, 1'b1, rand64(), rand64());
        queue_rule('0, 1'b1, 1'b0, 1'b1, rand64(), rand64());
        queue_word(cif_pkg::OP_REMOVE, id_pool[2], 0, '0);

        queue_random_words(RANDOM_PER_PHASE);
        wait_until_drained();

        // phase two: the other way round
        send_idle_pct  = 78;
        recv_stall_pct = 30;
        queue_random_words(RANDOM_PER_PHASE);
        wait_until_drained();

        // phase three: full throughput
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random_words(RANDOM_PER_PHASE);
        wait_until_drained();

        // let any stray result word surface
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results still owed", 64'(expected_results.size()), '0);

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
